[src/tcspq_pkg.sv]
package tcspq_pkg;

    localparam int ID_W  = 5;
    localparam int OCC_W = 6;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef struct packed {
        t_op              opcode;
        logic [ID_W-1:0]  entry_id;
        logic             urgent;
    } t_in_item;

    typedef struct packed {
        logic             popped_valid;
        logic [ID_W-1:0]  popped_id;
        logic             popped_urgent;
        logic             was_empty;
        logic             dropped_full;
        logic [OCC_W-1:0] occupancy;
    } t_out_item;

    // One stored slot: class bit above the id.
    typedef struct packed {
        logic            urgent;
        logic [ID_W-1:0] id;
    } t_slot;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN,
        ST_PLACE,
        ST_RESP
    } t_state;

endpackage

[src/tcspq_store.sv]
module tcspq_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  tcspq_pkg::t_slot     i_wr_data,
    input  logic [AW-1:0]        i_rd_addr,
    output tcspq_pkg::t_slot     o_rd_data
);
    import tcspq_pkg::*;

    t_slot r_mem [DEPTH];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/two_class_stable_priority_queue.sv]
// Two-class FIFO of 5-bit entry ids held in a single-port-write, single-port-read
// ring memory of QUEUE_DEPTH slots. One item is worked on at a time and the input
// stalls until its result has been loaded into the output register. A normal enqueue,
// a refused enqueue into a full queue and a dequeue from an empty queue go straight
// to the result state; a dequeue first passes the pop state because of the registered
// memory read. An urgent enqueue into a non-empty queue walks back from the tail
// one slot per cycle, moving each normal entry up by one until it meets the last
// urgent entry; that walk over the memory read and write ports sets the worst case.
// The slot memory is not cleared after reset, since only data from slots holding
// entries is ever used.
module two_class_stable_priority_queue #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  tcspq_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output tcspq_pkg::t_out_item  o_out_item
);
    import tcspq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_state            r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_wptr, n_wptr;
    logic [AW-1:0]     r_rptr, n_rptr;
    logic [AW-1:0]     r_left, n_left;
    t_slot             r_word, n_word;
    t_out_item         r_res, n_res;
    logic              n_out_valid;
    t_out_item         n_out_item;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    t_slot             wr_data;
    logic [AW-1:0]     rd_addr;
    t_slot             rd_data;
    logic              full;
    logic              empty;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - 1'b1;
    endfunction

    tcspq_store #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign full       = (r_count == CW'(QUEUE_DEPTH));
    assign empty      = (r_count == '0);
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_wptr      = r_wptr;
        n_rptr      = r_rptr;
        n_left      = r_left;
        n_word      = r_word;
        n_res       = r_res;
        n_out_valid = o_out_valid && i_out_stall;
        n_out_item  = o_out_item;
        wr_en       = 1'b0;
        wr_addr     = r_tail;
        wr_data     = r_word;
        rd_addr     = r_head;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_res           = '0;
                    n_res.occupancy = OCC_W'(r_count);
                    n_state         = ST_RESP;
                    if (i_in_item.opcode == OP_ENQ) begin
                        if (full) begin
                            n_res.dropped_full = 1'b1;
                        end else if (!i_in_item.urgent || empty) begin
                            wr_en           = 1'b1;
                            wr_addr         = r_tail;
                            wr_data         = '{urgent: i_in_item.urgent,
                                                id: i_in_item.entry_id};
                            n_tail          = ring_inc(r_tail);
                            n_count         = r_count + 1'b1;
                            n_res.occupancy = OCC_W'(n_count);
                        end else begin
                            // Walk back from the tail, starting with the last entry.
                            n_word  = '{urgent: 1'b1, id: i_in_item.entry_id};
                            n_wptr  = r_tail;
                            n_rptr  = ring_dec(r_tail);
                            rd_addr = ring_dec(r_tail);
                            n_left  = AW'(r_count);
                            n_state = ST_SCAN;
                        end
                    end else begin
                        if (empty) begin
                            n_res.was_empty = 1'b1;
                        end else begin
                            rd_addr = r_head;
                            n_state = ST_POP;
                        end
                    end
                end
            end
            ST_POP: begin
                n_res.popped_valid  = 1'b1;
                n_res.popped_id     = rd_data.id;
                n_res.popped_urgent = rd_data.urgent;
                n_head              = ring_inc(r_head);
                n_count             = r_count - 1'b1;
                n_res.occupancy     = OCC_W'(n_count);
                n_state             = ST_RESP;
            end
            ST_SCAN: begin
                wr_en   = 1'b1;
                wr_addr = r_wptr;
                if (rd_data.urgent) begin
                    // Urgent entries form a prefix, so the new entry lands right behind it.
                    wr_data         = r_word;
                    n_tail          = ring_inc(r_tail);
                    n_count         = r_count + 1'b1;
                    n_res.occupancy = OCC_W'(n_count);
                    n_state         = ST_RESP;
                end else begin
                    wr_data = rd_data;
                    n_wptr  = r_rptr;
                    n_rptr  = ring_dec(r_rptr);
                    rd_addr = ring_dec(r_rptr);
                    n_left  = r_left - 1'b1;
                    if (r_left == AW'(1)) begin
                        n_state = ST_PLACE;
                    end
                end
            end
            ST_PLACE: begin
                wr_en           = 1'b1;
                wr_addr         = r_wptr;
                wr_data         = r_word;
                n_tail          = ring_inc(r_tail);
                n_count         = r_count + 1'b1;
                n_res.occupancy = OCC_W'(n_count);
                n_state         = ST_RESP;
            end
            ST_RESP: begin
                if (!o_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_item  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            o_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wptr     <= n_wptr;
        r_rptr     <= n_rptr;
        r_left     <= n_left;
        r_word     <= n_word;
        r_res      <= n_res;
        o_out_item <= n_out_item;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_tail_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail == ((32'(r_head) + 32'(r_count) >= 32'(QUEUE_DEPTH))
                   ? AW'(32'(r_head) + 32'(r_count) - 32'(QUEUE_DEPTH))
                   : AW'(32'(r_head) + 32'(r_count))))
        else $error("tail pointer out of step with head and count");

    a_out_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_RESP))
        else $error("result presented outside the result state");

    a_scan_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_left != '0))
        else $error("slot walk ran past the head");
`endif

endmodule
